### rtl/core/cplr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplr_pkg
// Shared types and constants for the clipped patterned line rasterizer.
// ----------------------------------------------------------------------------
package cplr_pkg;

  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int REG_W    = 13;
  localparam int PIX_W    = 12;
  localparam int COLOR_W  = 8;
  localparam int PAT_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_L   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_T   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_R   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_B   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR    = 3'd7;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [PAT_W-1:0] SOLID_PATTERN = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [REG_W-1:0] screen_w;
    logic [REG_W-1:0] screen_h;
    logic [REG_W-1:0] clip_l;
    logic [REG_W-1:0] clip_t;
    logic [REG_W-1:0] clip_r;
    logic [REG_W-1:0] clip_b;
    logic [PAT_W-1:0] pattern;
    logic [COLOR_W-1:0] color;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
    logic [COLOR_W-1:0] color;
    logic               valid;
    logic               done;
  } res_t;

endpackage

### rtl/core/cplr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cplr_div #(
  parameter int W = 36
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W:0]    r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [W:0]    sh;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    sh = {r_r[W-1:0], q_r[W-1]};
    if (start) begin
      q_nxt = num; r_nxt = '0; d_nxt = den; cnt_nxt = CW'(W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, d_r}) begin
        r_nxt = sh - {1'b0, d_r};
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = sh;
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;
endmodule

### rtl/core/cplr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplr_front
// Accepts items, clips load endpoints with a shared multiplier and divider,
// and forwards a decoded command to the step engine through a short queue.
// ----------------------------------------------------------------------------
module cplr_front #(
  parameter int CW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cplr_pkg::cfg_t        cfg,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_cmd,
  input  logic signed [CW-1:0]  in_x_start,
  input  logic signed [CW-1:0]  in_y_start,
  input  logic signed [CW-1:0]  in_x_end,
  input  logic signed [CW-1:0]  in_y_end,
  output logic                  q_push,
  input  logic                  q_full,
  output logic [4+5*(CW+2)-1:0] q_data
);
  import cplr_pkg::*;

  localparam int VW = CW + 2;           // working coordinate width
  localparam int MW = 2 * VW + 1;       // product / divider width

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLIP  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_APPLY = 7'b0100000,
    S_SEND  = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;
  logic signed [VW-1:0] x1_r, y1_r, x2_r, y2_r, dx_r, dy_r;
  logic signed [VW-1:0] x1_nxt, y1_nxt, x2_nxt, y2_nxt, dx_nxt, dy_nxt;
  logic [2:0] ph_r, ph_nxt;         // clip phase 0..3
  logic rej_r, rej_nxt, cmd_r, cmd_nxt, neg_r, neg_nxt;
  logic signed [VW-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [MW-1:0] prod_r, prod_nxt;

  logic div_start, div_busy;
  logic [MW-1:0] div_q;

  cplr_div #(.W(MW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(prod_r), .den(MW'(c_r[VW-1] ? -c_r : c_r)),
    .busy(div_busy), .quo(div_q)
  );

  logic signed [VW-1:0] w, h, wm1, hm1, scl;
  logic need;
  logic signed [VW-1:0] aa, bb, cc;
  logic signed [VW-1:0] sx1, sy1, sx2, sy2, t;
  logic solid, ymaj, mdown;
  logic [VW-1:0] adx, ady, mrun, nrun;
  logic [VW-1:0] ma, mb;

  always_comb begin
    w = VW'($signed({1'b0, cfg.screen_w}));
    h = VW'($signed({1'b0, cfg.screen_h}));
    wm1 = w - VW'(1);
    hm1 = h - VW'(1);
    t = '0;
    st_nxt = st_r;
    x1_nxt = x1_r; y1_nxt = y1_r; x2_nxt = x2_r; y2_nxt = y2_r;
    dx_nxt = dx_r; dy_nxt = dy_r; ph_nxt = ph_r; rej_nxt = rej_r;
    cmd_nxt = cmd_r; neg_nxt = neg_r; a_nxt = a_r; b_nxt = b_r; c_nxt = c_r;
    prod_nxt = prod_r;
    div_start = 1'b0;
    need = 1'b0; aa = '0; bb = '0; cc = '0;
    ma = a_r[VW-1] ? VW'(-a_r) : VW'(a_r);
    mb = b_r[VW-1] ? VW'(-b_r) : VW'(b_r);
    scl = neg_r ? -VW'(div_q) : VW'(div_q);
    case (st_r)
      S_IDLE: begin
        if (in_push) begin
          cmd_nxt = in_cmd;
          x1_nxt = VW'(in_x_start); y1_nxt = VW'(in_y_start);
          x2_nxt = VW'(in_x_end);   y2_nxt = VW'(in_y_end);
          dx_nxt = VW'(in_x_end) - VW'(in_x_start);
          dy_nxt = VW'(in_y_end) - VW'(in_y_start);
          rej_nxt = 1'b0; ph_nxt = '0;
          st_nxt = (in_cmd == CMD_LOAD) ? S_CLIP : S_SEND;
        end
      end
      S_CLIP: begin
        // each phase: at most one scaled move, after a reject test in phases 0 and 2
        case (ph_r)
          3'd0: begin
            if (!dx_r[VW-1]) begin
              if (x1_r >= w || x2_r < 0) rej_nxt = 1'b1;
              else if (x1_r < 0) begin
                need = (dy_r != 0); aa = -x1_r; bb = dy_r; cc = dx_r;
                if (!need) x1_nxt = '0;
              end
            end else begin
              if (x2_r >= w || x1_r < 0) rej_nxt = 1'b1;
              else if (x2_r < 0) begin
                need = (dy_r != 0); aa = -x2_r; bb = dy_r; cc = dx_r;
                if (!need) x2_nxt = '0;
              end
            end
          end
          3'd1: begin
            if (!dx_r[VW-1]) begin
              if (x2_r >= w) begin
                need = (dy_r != 0); aa = wm1 - x2_r; bb = dy_r; cc = dx_r;
                if (!need) x2_nxt = wm1;
              end
            end else if (x1_r >= w) begin
              need = (dy_r != 0); aa = wm1 - x1_r; bb = dy_r; cc = dx_r;
              if (!need) x1_nxt = wm1;
            end
          end
          3'd2: begin
            if (!dy_r[VW-1]) begin
              if (y1_r >= h || y2_r < 0) rej_nxt = 1'b1;
              else if (y1_r < 0) begin
                need = (dx_r != 0); aa = -y1_r; bb = dx_r; cc = dy_r;
                if (!need) begin y1_nxt = '0; if (x1_r < 0) x1_nxt = '0; end
              end
            end else begin
              if (y2_r >= h || y1_r < 0) rej_nxt = 1'b1;
              else if (y2_r < 0) begin
                need = (dx_r != 0); aa = -y2_r; bb = dx_r; cc = dy_r;
                if (!need) begin y2_nxt = '0; if (x2_r < 0) x2_nxt = '0; end
              end
            end
          end
          default: begin
            if (!dy_r[VW-1]) begin
              if (y2_r >= h) begin
                need = (dx_r != 0); aa = hm1 - y2_r; bb = dx_r; cc = dy_r;
                if (!need) begin y2_nxt = hm1; if (x2_r < 0) x2_nxt = '0; end
              end
            end else if (y1_r >= h) begin
              need = (dx_r != 0); aa = hm1 - y1_r; bb = dx_r; cc = dy_r;
              if (!need) begin y1_nxt = hm1; if (x1_r < 0) x1_nxt = '0; end
            end
          end
        endcase
        a_nxt = aa; b_nxt = bb; c_nxt = cc;
        neg_nxt = (aa[VW-1] ^ bb[VW-1]) ^ cc[VW-1];
        if (rej_nxt) st_nxt = S_SEND;
        else if (need) st_nxt = S_MUL;
        else if (ph_r == 3'd3) st_nxt = S_SEND;
        else ph_nxt = ph_r + 3'd1;
      end
      S_MUL: begin
        prod_nxt = MW'(ma) * MW'(mb);
        st_nxt = S_DIV;
      end
      S_DIV: begin
        div_start = 1'b1;
        st_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!div_busy) st_nxt = S_APPLY;
      end
      S_APPLY: begin
        case (ph_r)
          3'd0: if (!dx_r[VW-1]) begin y1_nxt = y1_r + scl; x1_nxt = '0; end
                else begin y2_nxt = y2_r + scl; x2_nxt = '0; end
          3'd1: if (!dx_r[VW-1]) begin y2_nxt = y2_r + scl; x2_nxt = wm1; end
                else begin y1_nxt = y1_r + scl; x1_nxt = wm1; end
          3'd2: if (!dy_r[VW-1]) begin
                  t = x1_r + scl; x1_nxt = t[VW-1] ? '0 : t; y1_nxt = '0;
                end else begin
                  t = x2_r + scl; x2_nxt = t[VW-1] ? '0 : t; y2_nxt = '0;
                end
          default: if (!dy_r[VW-1]) begin
                  t = x2_r + scl; x2_nxt = t[VW-1] ? '0 : t; y2_nxt = hm1;
                end else begin
                  t = x1_r + scl; x1_nxt = t[VW-1] ? '0 : t; y1_nxt = hm1;
                end
        endcase
        if (ph_r == 3'd3) st_nxt = S_SEND;
        else begin ph_nxt = ph_r + 3'd1; st_nxt = S_CLIP; end
      end
      S_SEND: begin
        if (!q_full) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // order endpoints and pick axes for the queued command
  always_comb begin
    solid = (cfg.pattern == '0) || (cfg.pattern == SOLID_PATTERN);
    sx1 = x1_r; sy1 = y1_r; sx2 = x2_r; sy2 = y2_r;
    adx = (dx_r[VW-1] ? VW'(-dx_r) : VW'(dx_r)) + 1'b1;
    ady = (dy_r[VW-1] ? VW'(-dy_r) : VW'(dy_r)) + 1'b1;
    mdown = 1'b0;
    if (solid && x1_r == x2_r) begin
      ymaj = 1'b1; mrun = VW'(1); nrun = '0;
      if (y2_r < y1_r) begin sy1 = y2_r; sy2 = y1_r; end
    end else if (solid && y1_r == y2_r) begin
      ymaj = 1'b0; mrun = VW'(1); nrun = '0;
      if (x2_r < x1_r) begin sx1 = x2_r; sx2 = x1_r; end
    end else if (adx >= ady) begin
      ymaj = 1'b0; mrun = adx; nrun = ady;
      if (x2_r < x1_r) begin sx1 = x2_r; sx2 = x1_r; sy1 = y2_r; sy2 = y1_r; end
      mdown = !(sy2 > sy1);
    end else begin
      ymaj = 1'b1; mrun = ady; nrun = adx;
      if (y2_r < y1_r) begin sx1 = x2_r; sx2 = x1_r; sy1 = y2_r; sy2 = y1_r; end
      mdown = !(sx2 > sx1);
    end
  end

  assign in_full = (st_r != S_IDLE);
  assign q_push  = (st_r == S_SEND) && !q_full;
  assign q_data  = {cmd_r, rej_r, ymaj, mdown,
                    ymaj ? sy1 : sx1, ymaj ? sy2 : sx2, ymaj ? sx1 : sy1,
                    mrun, nrun};

  always_ff @(posedge clk) begin
    x1_r <= x1_nxt; y1_r <= y1_nxt; x2_r <= x2_nxt; y2_r <= y2_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; ph_r <= ph_nxt; rej_r <= rej_nxt;
    cmd_r <= cmd_nxt; neg_r <= neg_nxt; a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt;
    prod_r <= prod_nxt;
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end
endmodule

### rtl/core/cplr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplr_back
// Command queue and step engine: holds line state, emits one result per
// command into a one-entry output register.
// ----------------------------------------------------------------------------
module cplr_back #(
  parameter int CW = 16,
  parameter int PATTERN_LENGTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cplr_pkg::cfg_t     cfg,
  input  logic               q_push,
  output logic               q_full,
  input  logic [4+5*(CW+2)-1:0] q_data,
  output logic               out_empty,
  input  logic               out_pop,
  output cplr_pkg::res_t     res,
  output logic               busy
);
  import cplr_pkg::*;

  localparam int VW = CW + 2;
  localparam int QW = 4 + 5 * VW;
  localparam int PW = $clog2(PATTERN_LENGTH);
  localparam int EW = VW + 1;

  // two-entry command queue
  logic [QW-1:0] qm_r [2];
  logic [1:0] qcnt_r, qcnt_nxt;
  logic qwp_r, qrp_r;
  logic deq;

  logic signed [VW-1:0] cmaj_r, cmin_r, emaj_r;
  logic [EW-1:0] err_r, mrun_r, nrun_r;
  logic mdown_r, ymaj_r, act_r;
  logic [PW-1:0] pidx_r;
  res_t out_r, res_nxt;
  logic full_r;

  logic c_cmd, c_rej, c_ymaj, c_mdown;
  logic signed [VW-1:0] c_s, c_e, c_m;
  logic [VW-1:0] c_mr, c_nr;
  logic signed [VW-1:0] px, py, cmaj_inc;
  logic pat, in_clip, solid;
  logic [EW-1:0] esum;

  assign {c_cmd, c_rej, c_ymaj, c_mdown, c_s, c_e, c_m, c_mr, c_nr} = qm_r[qrp_r];
  assign q_full = (qcnt_r == 2'd2);
  assign deq = (qcnt_r != 2'd0) && (!full_r || out_pop);
  assign solid = (cfg.pattern == '0) || (cfg.pattern == SOLID_PATTERN);
  assign px = ymaj_r ? cmin_r : cmaj_r;
  assign py = ymaj_r ? cmaj_r : cmin_r;
  assign pat = solid || ((32'(pidx_r) < 32'd32) && cfg.pattern[5'(pidx_r)]);
  assign in_clip = !px[VW-1] && !py[VW-1] &&
                   px >= VW'(cfg.clip_l) && px < VW'(cfg.clip_r) &&
                   py >= VW'(cfg.clip_t) && py < VW'(cfg.clip_b);
  assign esum = err_r + nrun_r;
  assign cmaj_inc = cmaj_r + 1'b1;

  always_comb begin
    qcnt_nxt = qcnt_r;
    if (q_push && !deq) qcnt_nxt = qcnt_r + 2'd1;
    else if (!q_push && deq) qcnt_nxt = qcnt_r - 2'd1;
  end

  always_comb begin
    res_nxt = '0;
    if (c_cmd == CMD_LOAD) begin
      res_nxt.done = c_rej;
    end else if (!act_r) begin
      res_nxt.done = 1'b1;
    end else begin
      res_nxt.px = PIX_W'(px);
      res_nxt.py = PIX_W'(py);
      res_nxt.color = cfg.color;
      res_nxt.valid = pat && in_clip;
      res_nxt.done = (cmaj_inc > emaj_r);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) qm_r[qwp_r] <= q_data;
    if (!rst_n) begin
      qcnt_r <= '0; qwp_r <= 1'b0; qrp_r <= 1'b0; full_r <= 1'b0; act_r <= 1'b0;
      cmaj_r <= '0; cmin_r <= '0; emaj_r <= '0; err_r <= '0; mrun_r <= '0;
      nrun_r <= '0; mdown_r <= 1'b0; ymaj_r <= 1'b0; pidx_r <= '0;
    end else begin
      qcnt_r <= qcnt_nxt;
      if (q_push) qwp_r <= !qwp_r;
      if (out_pop && full_r && !deq) full_r <= 1'b0;
      if (deq) begin
        qrp_r <= !qrp_r;
        full_r <= 1'b1;
        out_r <= res_nxt;
        if (c_cmd == CMD_LOAD) begin
          act_r <= !c_rej;
          if (!c_rej) begin
            ymaj_r <= c_ymaj; mdown_r <= c_mdown; cmaj_r <= c_s; emaj_r <= c_e;
            cmin_r <= c_m; mrun_r <= EW'(c_mr); nrun_r <= EW'(c_nr);
            err_r <= '0; pidx_r <= '0;
          end
        end else if (act_r) begin
          if (!solid)
            pidx_r <= (pidx_r == PW'(PATTERN_LENGTH - 1)) ? '0 : pidx_r + 1'b1;
          if (esum >= mrun_r) begin
            err_r <= esum - mrun_r;
            cmin_r <= mdown_r ? cmin_r - 1'b1 : cmin_r + 1'b1;
          end else err_r <= esum;
          cmaj_r <= cmaj_inc;
          act_r <= !(cmaj_inc > emaj_r);
        end
      end
    end
  end

  assign out_empty = !full_r;
  assign res = out_r;
  assign busy = (qcnt_r != 2'd0);
endmodule

### rtl/core/clipped_patterned_line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_patterned_line_rasterizer
// Load items are clipped in the front, with up to four clip divisions on a serial
// divider; the front takes one item at a time and keeps full high until it is queued.
// Reset: synchronous active low; registers take screen 640x480, solid
// pattern, color 0, line idle.
// ----------------------------------------------------------------------------
module clipped_patterned_line_rasterizer #(
  parameter int COORD_WIDTH = 16,
  parameter int PATTERN_LENGTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cplr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cplr_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_cmd,
  input  logic signed [COORD_WIDTH-1:0] in_x_start,
  input  logic signed [COORD_WIDTH-1:0] in_y_start,
  input  logic signed [COORD_WIDTH-1:0] in_x_end,
  input  logic signed [COORD_WIDTH-1:0] in_y_end,
  output logic                          empty,
  input  logic                          pop,
  output logic [cplr_pkg::PIX_W-1:0]    out_pixel_x,
  output logic [cplr_pkg::PIX_W-1:0]    out_pixel_y,
  output logic [cplr_pkg::COLOR_W-1:0]  out_pixel_color,
  output logic                          out_pixel_valid,
  output logic                          out_line_done
);
  import cplr_pkg::*;

  localparam int VW = COORD_WIDTH + 2;
  localparam int QW = 4 + 5 * VW;

  cfg_t cfg_r;
  logic q_push, q_full, busy;
  logic [QW-1:0] q_data;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_w <= 13'd640; cfg_r.screen_h <= 13'd480;
      cfg_r.clip_l <= '0; cfg_r.clip_t <= '0;
      cfg_r.clip_r <= 13'd640; cfg_r.clip_b <= 13'd480;
      cfg_r.pattern <= '0; cfg_r.color <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_W: cfg_r.screen_w <= cfg_data[REG_W-1:0];
        REG_SCREEN_H: cfg_r.screen_h <= cfg_data[REG_W-1:0];
        REG_CLIP_L:   cfg_r.clip_l   <= cfg_data[REG_W-1:0];
        REG_CLIP_T:   cfg_r.clip_t   <= cfg_data[REG_W-1:0];
        REG_CLIP_R:   cfg_r.clip_r   <= cfg_data[REG_W-1:0];
        REG_CLIP_B:   cfg_r.clip_b   <= cfg_data[REG_W-1:0];
        REG_PATTERN:  cfg_r.pattern  <= cfg_data[PAT_W-1:0];
        REG_COLOR:    cfg_r.color    <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  cplr_front #(.CW(COORD_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_push(push), .in_full(full), .in_cmd(in_cmd),
    .in_x_start(in_x_start), .in_y_start(in_y_start),
    .in_x_end(in_x_end), .in_y_end(in_y_end),
    .q_push(q_push), .q_full(q_full), .q_data(q_data)
  );

  cplr_back #(.CW(COORD_WIDTH), .PATTERN_LENGTH(PATTERN_LENGTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_push(q_push), .q_full(q_full), .q_data(q_data),
    .out_empty(empty), .out_pop(pop), .res(res), .busy(busy)
  );

  assign out_pixel_x     = res.px;
  assign out_pixel_y     = res.py;
  assign out_pixel_color = res.color;
  assign out_pixel_valid = res.valid;
  assign out_line_done   = res.done;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push) else $error("queue overrun");
  a_valid_not_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_pixel_valid) |-> (out_pixel_color == cfg_r.color))
    else $error("pixel color mismatch");
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (busy || !empty)) else $error("queued item lost");
endmodule

### bench/clipped_patterned_line_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_patterned_line_rasterizer_tb
// Drives line loads and pixel steps through the queue-style ports under
// random gaps and stalls. A local line predictor (clipping, ordering, error
// accumulation, dash pattern, clip test) supplies the expected pixel for every
// accepted item without a fixed result in the directed table. The run covers
// several register settings, the extreme ones among them.
// ----------------------------------------------------------------------------
module clipped_patterned_line_rasterizer_tb;
  import cplr_pkg::*;

  typedef struct packed {
    logic        cmd;
    logic [15:0] x1;
    logic [15:0] y1;
    logic [15:0] x2;
    logic [15:0] y2;
    logic        typed;
    res_t        res;
  } row_t;

  localparam res_t R_DONE = '{px: '0, py: '0, color: '0, valid: 1'b0, done: 1'b1};
  localparam res_t R_LOADED = '{px: '0, py: '0, color: '0, valid: 1'b0, done: 1'b0};
  localparam res_t R_NONE = '{default: '0};
  localparam int DIR_N = 25;

  localparam row_t DIR_TAB [0:DIR_N-1] = '{
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, R_DONE},
    '{CMD_LOAD, 16'd700, 16'd10, 16'd800, 16'd20, 1'b1, R_DONE},
    '{CMD_LOAD, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 1'b1, R_DONE},
    '{CMD_LOAD, 16'd10, 16'd10, 16'd10, 16'd13, 1'b1, R_LOADED},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE},
    '{CMD_STEP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, R_NONE},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE},
    '{CMD_LOAD, 16'd0, 16'd0, 16'd5, 16'd2, 1'b1, R_LOADED},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, R_DONE},
    '{CMD_LOAD, 16'h8000, -16'd100, 16'h7FFF, 16'd500, 1'b0, R_NONE},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE},
    '{CMD_LOAD, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b0, R_NONE},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE},
    '{CMD_LOAD, 16'd639, 16'd479, 16'd639, 16'd479, 1'b0, R_NONE},
    '{CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, R_NONE}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic push;
  logic full;
  logic in_cmd;
  logic signed [15:0] in_x_start, in_y_start, in_x_end, in_y_end;
  logic empty;
  logic pop;
  logic [PIX_W-1:0] out_pixel_x, out_pixel_y;
  logic [COLOR_W-1:0] out_pixel_color;
  logic out_pixel_valid, out_line_done;

  clipped_patterned_line_rasterizer dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .in_cmd(in_cmd),
    .in_x_start(in_x_start), .in_y_start(in_y_start),
    .in_x_end(in_x_end), .in_y_end(in_y_end),
    .empty(empty), .pop(pop),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_pixel_color(out_pixel_color), .out_pixel_valid(out_pixel_valid),
    .out_line_done(out_line_done)
  );

  // predictor copy of registers and line state
  longint scr_w, scr_h, clp_l, clp_t, clp_r, clp_b;
  logic [31:0] dash;
  logic [7:0] color;
  longint maj, mnr, maj_end, err_acc, maj_run, mnr_run;
  bit mnr_down, y_major, drawing;
  int dash_idx;

  res_t pixel_q[$];
  int errors = 0;
  int items_sent = 0;
  int pixels_got = 0;
  int lines_loaded = 0;
  int dashed_pixels = 0;
  int pop_hold = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint scale(longint a, longint b, longint c);
    if (c == 0) return 0;
    return (a * b) / c;
  endfunction

  function automatic bit solid_dash();
    return dash == '0 || dash == SOLID_PATTERN;
  endfunction

  function automatic void load_line(longint x1, longint y1, longint x2, longint y2);
    longint dx, dy, t, adx, ady;
    dx = x2 - x1;
    dy = y2 - y1;
    drawing = 1'b0;
    if (dx >= 0) begin
      if (x1 >= scr_w || x2 < 0) return;
      if (x1 < 0) begin if (dy != 0) y1 += scale(-x1, dy, dx); x1 = 0; end
      if (x2 >= scr_w) begin
        if (dy != 0) y2 += scale(scr_w - 1 - x2, dy, dx);
        x2 = scr_w - 1;
      end
    end else begin
      if (x2 >= scr_w || x1 < 0) return;
      if (x2 < 0) begin if (dy != 0) y2 += scale(-x2, dy, dx); x2 = 0; end
      if (x1 >= scr_w) begin
        if (dy != 0) y1 += scale(scr_w - 1 - x1, dy, dx);
        x1 = scr_w - 1;
      end
    end
    if (dy >= 0) begin
      if (y1 >= scr_h || y2 < 0) return;
      if (y1 < 0) begin
        if (dx != 0) x1 += scale(-y1, dx, dy);
        y1 = 0;
        if (x1 < 0) x1 = 0;
      end
      if (y2 >= scr_h) begin
        if (dx != 0) x2 += scale(scr_h - 1 - y2, dx, dy);
        y2 = scr_h - 1;
        if (x2 < 0) x2 = 0;
      end
    end else begin
      if (y2 >= scr_h || y1 < 0) return;
      if (y2 < 0) begin
        if (dx != 0) x2 += scale(-y2, dx, dy);
        y2 = 0;
        if (x2 < 0) x2 = 0;
      end
      if (y1 >= scr_h) begin
        if (dx != 0) x1 += scale(scr_h - 1 - y1, dx, dy);
        y1 = scr_h - 1;
        if (x1 < 0) x1 = 0;
      end
    end
    adx = (dx < 0 ? -dx : dx) + 1;
    ady = (dy < 0 ? -dy : dy) + 1;
    if (solid_dash() && x1 == x2) begin
      y_major = 1'b1;
      if (y2 < y1) begin t = y1; y1 = y2; y2 = t; end
      maj_run = 1; mnr_run = 0; mnr_down = 1'b0;
    end else if (solid_dash() && y1 == y2) begin
      y_major = 1'b0;
      if (x2 < x1) begin t = x1; x1 = x2; x2 = t; end
      maj_run = 1; mnr_run = 0; mnr_down = 1'b0;
    end else if (adx >= ady) begin
      y_major = 1'b0;
      if (x2 < x1) begin t = x1; x1 = x2; x2 = t; t = y1; y1 = y2; y2 = t; end
      mnr_down = !(y2 > y1);
      maj_run = adx; mnr_run = ady;
    end else begin
      y_major = 1'b1;
      if (y2 < y1) begin t = x1; x1 = x2; x2 = t; t = y1; y1 = y2; y2 = t; end
      mnr_down = !(x2 > x1);
      maj_run = ady; mnr_run = adx;
    end
    if (y_major) begin maj = y1; maj_end = y2; mnr = x1; end
    else begin maj = x1; maj_end = x2; mnr = y1; end
    err_acc = 0;
    dash_idx = 0;
    drawing = 1'b1;
  endfunction

  function automatic res_t next_pixel(logic cmd, logic signed [15:0] x1,
                                      logic signed [15:0] y1, logic signed [15:0] x2,
                                      logic signed [15:0] y2);
    res_t r;
    longint px, py;
    bit on;
    r = R_NONE;
    if (cmd == CMD_LOAD) begin
      load_line(x1, y1, x2, y2);
      r.done = !drawing;
      return r;
    end
    if (!drawing) begin
      r.done = 1'b1;
      return r;
    end
    px = y_major ? mnr : maj;
    py = y_major ? maj : mnr;
    on = 1'b1;
    if (!solid_dash()) begin
      on = dash[dash_idx];
      dash_idx = (dash_idx + 1) % 32;
      dashed_pixels++;
    end
    r.px = px[11:0];
    r.py = py[11:0];
    r.color = color;
    r.valid = on && px >= clp_l && px < clp_r && py >= clp_t && py < clp_b;
    err_acc += mnr_run;
    if (err_acc >= maj_run) begin
      err_acc -= maj_run;
      mnr += mnr_down ? -1 : 1;
    end
    maj += 1;
    if (maj > maj_end) drawing = 1'b0;
    r.done = !drawing;
    return r;
  endfunction

  task automatic send_item(logic cmd, logic [15:0] x1, logic [15:0] y1,
                           logic [15:0] x2, logic [15:0] y2, bit typed, res_t want);
    res_t r;
    push <= 1'b1;
    in_cmd <= cmd;
    in_x_start <= x1;
    in_y_start <= y1;
    in_x_end <= x2;
    in_y_end <= y2;
    do @(posedge clk); while (full);
    r = next_pixel(cmd, x1, y1, x2, y2);
    pixel_q.push_back(typed ? want : r);
    items_sent++;
    if (cmd == CMD_LOAD && drawing) lines_loaded++;
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (r >= 97) n = $urandom_range(15, 60);
    else if (r >= 75) n = $urandom_range(1, 3);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    // keep the clock running after the last expected result so stray results are reported
    repeat (300) @(posedge clk);
  endtask

  task automatic write_regs(int sw, int sh, int cl, int ct, int cr, int cb,
                            logic [31:0] pat, logic [7:0] col);
    logic [31:0] vals [8];
    vals = '{sw, sh, cl, ct, cr, cb, pat, col};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    scr_w = sw; scr_h = sh; clp_l = cl; clp_t = ct; clp_r = cr; clp_b = cb;
    dash = pat;
    color = col;
  endtask

  function automatic logic [15:0] near_coord(longint lim);
    return 16'($urandom_range(0, lim + 40) - 20);
  endfunction

  task automatic draw_lines(int quota);
    logic [15:0] x1, y1, x2, y2;
    int r, span, steps;
    while (quota > 0) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_item(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 1'b0, R_NONE);
        quota--;
        idle_gap();
        continue;
      end
      if (r < 25) begin
        x1 = 16'($urandom); y1 = 16'($urandom);
        x2 = 16'($urandom); y2 = 16'($urandom);
      end else begin
        span = (r < 30) ? 4096 : 24;
        x1 = near_coord(scr_w); y1 = near_coord(scr_h);
        x2 = x1 + 16'($urandom_range(0, 2 * span) - span);
        y2 = y1 + 16'($urandom_range(0, 2 * span) - span);
        if (r < 36) x2 = x1;
        else if (r < 42) y2 = y1;
      end
      send_item(CMD_LOAD, x1, y1, x2, y2, 1'b0, R_NONE);
      quota--;
      idle_gap();
      steps = 0;
      while (drawing && steps < 70 && quota > 0) begin
        send_item(CMD_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 1'b0, R_NONE);
        steps++;
        quota--;
        idle_gap();
      end
      if ($urandom_range(0, 3) == 0) begin
        send_item(CMD_STEP, '0, '0, '0, '0, 1'b0, R_NONE);
        quota--;
        idle_gap();
      end
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    int roll;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        pixels_got++;
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item x=%0d y=%0d", $realtime, out_pixel_x, out_pixel_y);
        end else begin
          want = pixel_q.pop_front();
          if (out_pixel_x !== want.px) begin
            errors++;
            $display("%0t: pixel_x expected %0d got %0d", $realtime, want.px, out_pixel_x);
          end
          if (out_pixel_y !== want.py) begin
            errors++;
            $display("%0t: pixel_y expected %0d got %0d", $realtime, want.py, out_pixel_y);
          end
          if (out_pixel_color !== want.color) begin
            errors++;
            $display("%0t: pixel_color expected %0d got %0d", $realtime, want.color,
                     out_pixel_color);
          end
          if (out_pixel_valid !== want.valid) begin
            errors++;
            $display("%0t: pixel_valid expected %0d got %0d", $realtime, want.valid,
                     out_pixel_valid);
          end
          if (out_line_done !== want.done) begin
            errors++;
            $display("%0t: line_done expected %0d got %0d", $realtime, want.done,
                     out_line_done);
          end
        end
      end
      if (pop_hold > 0) begin
        pop_hold <= pop_hold - 1;
        pop <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          pop_hold <= $urandom_range(15, 60);
          pop <= 1'b0;
        end else if (roll < 21) begin
          pop_hold <= $urandom_range(0, 2);
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    push = 1'b0;
    in_cmd = CMD_STEP;
    in_x_start = '0;
    in_y_start = '0;
    in_x_end = '0;
    in_y_end = '0;
    scr_w = 640; scr_h = 480; clp_l = 0; clp_t = 0; clp_r = 640; clp_b = 480;
    dash = '0;
    color = '0;
    maj = 0; mnr = 0; maj_end = 0; err_acc = 0; maj_run = 0; mnr_run = 0;
    mnr_down = 0; y_major = 0; drawing = 0; dash_idx = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      send_item(DIR_TAB[i].cmd, DIR_TAB[i].x1, DIR_TAB[i].y1, DIR_TAB[i].x2,
                DIR_TAB[i].y2, DIR_TAB[i].typed, DIR_TAB[i].res);
      idle_gap();
    end
    draw_lines(200);
    drain();

    write_regs(4096, 4096, 0, 0, 4096, 4096, SOLID_PATTERN, 8'hFF);
    draw_lines(220);
    drain();
    write_regs(1, 1, 0, 0, 1, 1, 32'h0000_0001, 8'h01);
    draw_lines(120);
    drain();
    write_regs(64, 48, 8, 4, 40, 30, 32'hF0F0_F0F0, 8'hA5);
    draw_lines(220);
    drain();
    write_regs($urandom_range(16, 300), $urandom_range(16, 300), $urandom_range(0, 100),
               $urandom_range(0, 100), $urandom_range(50, 4096), $urandom_range(50, 4096),
               $urandom, $urandom_range(0, 255));
    draw_lines(220);
    drain();
    write_regs(640, 480, 4096, 4096, 0, 0, 32'h8000_0000, 8'h00);
    draw_lines(150);
    drain();
    write_regs(4096, 1, 0, 0, 4096, 1, 32'h5555_5555, 8'h3C);
    draw_lines(150);
    drain();

    $display("%0d items sent, %0d lines drawn, %0d pixels checked (%0d dashed)",
             items_sent, lines_loaded, pixels_got, dashed_pixels);
    $display("covered 7 register settings incl. 4096x4096 and 1x1 screens");
    if (pixel_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### clipped_patterned_line_rasterizer.f
rtl/core/cplr_pkg.sv
rtl/core/cplr_div.sv
rtl/core/cplr_front.sv
rtl/core/cplr_back.sv
rtl/core/clipped_patterned_line_rasterizer.sv
bench/clipped_patterned_line_rasterizer_tb.sv
